// ----- src/mqttrx_pkg.sv -----
package mqttrx_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 256;

  // request function codes
  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
  localparam logic [2:0] ST_TIMEOUT    = 3'd2;
  localparam logic [2:0] ST_OVERSIZE   = 3'd3;
  localparam logic [2:0] ST_READ       = 3'd4;

  // configuration register indexes
  localparam logic CFG_BUFFER_SIZE = 1'b0;
  localparam logic CFG_TIMEOUT     = 1'b1;

  localparam logic [8:0]  BUFFER_SIZE_RESET = 9'd256;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd15;
  localparam int          MS_PER_SEC        = 1000;

  // store index after the fourth length byte
  localparam logic [8:0] LEN_INDEX_LIMIT = 9'd5;
  localparam logic [2:0] LEN_BYTES_MAX   = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] packet_length;
    logic [2:0] length_bytes;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [8:0] addr;
    logic [7:0] data;
  } store_wr_t;

endpackage

// ----- src/mqttrx_store.sv -----
module mqttrx_store import mqttrx_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk,
  input  store_wr_t  wr,
  input  logic       rd_en,
  input  logic [7:0] rd_index,
  output logic [7:0] rd_data
);

  // read_index is 8 bits wide, so entries at 256 and above are never read back
  localparam int MEM_DEPTH = BUFFER_DEPTH > 256 ? 256 : BUFFER_DEPTH;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [8:0] MEM_LIMIT = 9'(MEM_DEPTH);

  logic [7:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr < MEM_LIMIT)) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if ({1'b0, rd_index} < MEM_LIMIT) begin
        rd_data <= mem[rd_index[AW-1:0]];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// ----- src/mqttrx_decode.sv -----
module mqttrx_decode import mqttrx_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        emit,
  output result_t     result,
  output store_wr_t   store_wr
);

  localparam int CAP_INT = BUFFER_DEPTH > 511 ? 511 : BUFFER_DEPTH;
  localparam logic [8:0] DEPTH_CAP = 9'(CAP_INT);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  logic [8:0]  buffer_size;
  logic [25:0] timeout_limit;

  logic [1:0]  phase, phase_next;
  logic [8:0]  store_index, store_index_next;
  logic [27:0] remaining_length, remaining_length_next;
  logic [4:0]  length_shift, length_shift_next;
  logic [27:0] payload_count, payload_count_next;
  logic [28:0] total_count, total_count_next;
  logic [25:0] gap_millis, gap_millis_next;
  logic [2:0]  len_bytes, len_bytes_next;

  logic [8:0]  usable;
  logic [8:0]  sidx_inc;
  logic [27:0] rem_acc;
  logic [25:0] gap_inc;
  logic        wr_req;
  logic [8:0]  wr_addr;

  assign usable   = (buffer_size < DEPTH_CAP) ? buffer_size : DEPTH_CAP;
  assign sidx_inc = store_index + 9'd1;
  assign rem_acc  = remaining_length | ({21'd0, rx_byte[6:0]} << length_shift);
  assign gap_inc  = gap_millis + 26'd1;

  always_comb begin
    phase_next            = phase;
    store_index_next      = store_index;
    remaining_length_next = remaining_length;
    length_shift_next     = length_shift;
    payload_count_next    = payload_count;
    total_count_next      = total_count;
    gap_millis_next       = gap_millis;
    len_bytes_next        = len_bytes;
    emit                  = 1'b0;
    result                = '0;
    wr_req                = 1'b0;
    wr_addr               = store_index;

    case (func)
      FUNC_BYTE: begin
        gap_millis_next = '0;
        case (phase)
          PH_IDLE: begin
            wr_req                = 1'b1;
            wr_addr               = '0;
            store_index_next      = 9'd1;
            remaining_length_next = '0;
            length_shift_next     = '0;
            payload_count_next    = '0;
            total_count_next      = 29'd1;
            len_bytes_next        = '0;
            phase_next            = PH_LEN;
          end
          PH_LEN: begin
            wr_req                = 1'b1;
            store_index_next      = sidx_inc;
            total_count_next      = {20'd0, sidx_inc};
            remaining_length_next = rem_acc;
            length_shift_next     = length_shift + 5'd7;
            len_bytes_next        = len_bytes + 3'd1;
            if (rx_byte[7]) begin
              if (sidx_inc >= LEN_INDEX_LIMIT) begin
                emit                = 1'b1;
                result.status       = ST_BAD_LENGTH;
                result.length_bytes = LEN_BYTES_MAX;
                phase_next          = PH_IDLE;
              end
            end else if (rem_acc == '0) begin
              emit                = 1'b1;
              result.length_bytes = len_bytes_next;
              if ({20'd0, sidx_inc} > {20'd0, usable}) begin
                result.status = ST_OVERSIZE;
              end else begin
                result.status        = ST_DONE;
                result.packet_length = sidx_inc;
              end
              phase_next = PH_IDLE;
            end else begin
              payload_count_next = '0;
              phase_next         = PH_PAY;
            end
          end
          PH_PAY: begin
            if (store_index < usable) begin
              wr_req           = 1'b1;
              store_index_next = sidx_inc;
            end
            total_count_next   = total_count + 29'd1;
            payload_count_next = payload_count + 28'd1;
            if (payload_count_next >= remaining_length) begin
              emit                = 1'b1;
              result.length_bytes = len_bytes;
              if (total_count_next > {20'd0, usable}) begin
                result.status = ST_OVERSIZE;
              end else begin
                result.status        = ST_DONE;
                result.packet_length = store_index_next;
              end
              phase_next = PH_IDLE;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      FUNC_TICK: begin
        if (phase != PH_IDLE) begin
          gap_millis_next = gap_inc;
          if (gap_inc >= timeout_limit) begin
            emit          = 1'b1;
            result.status = ST_TIMEOUT;
            phase_next    = PH_IDLE;
          end
        end
      end
      FUNC_READ: begin
        emit          = 1'b1;
        result.status = ST_READ;
      end
      default: begin
      end
    endcase
  end

  assign store_wr.en   = accept && wr_req;
  assign store_wr.addr = wr_addr;
  assign store_wr.data = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size   <= BUFFER_SIZE_RESET;
      timeout_limit <= 26'(TIMEOUT_RESET * MS_PER_SEC);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BUFFER_SIZE: begin
          if (cfg_data[8:0] != '0) begin
            buffer_size <= cfg_data[8:0];
          end
        end
        CFG_TIMEOUT: begin
          timeout_limit <= 26'({10'd0, cfg_data} * 26'(MS_PER_SEC));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      store_index      <= '0;
      remaining_length <= '0;
      length_shift     <= '0;
      payload_count    <= '0;
      total_count      <= '0;
      gap_millis       <= '0;
      len_bytes        <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      store_index      <= store_index_next;
      remaining_length <= remaining_length_next;
      length_shift     <= length_shift_next;
      payload_count    <= payload_count_next;
      total_count      <= total_count_next;
      gap_millis       <= gap_millis_next;
      len_bytes        <= len_bytes_next;
    end
  end

endmodule

// ----- src/mqttrx_outq.sv -----
module mqttrx_outq import mqttrx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       emit,
  input  result_t    result,
  input  logic [7:0] rd_data,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [8:0] packet_length,
  output logic [2:0] length_bytes,
  output logic [7:0] read_data
);

  logic    res_valid;
  result_t res;
  logic    out_load;

  // res stage waits for the registered store read
  assign out_load = !out_valid || out_ready;
  assign in_ready = !res_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= res_valid;
      end
      if (in_ready) begin
        res_valid <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res <= result;
    end
    if (out_load && res_valid) begin
      status        <= res.status;
      packet_length <= res.packet_length;
      length_bytes  <= res.length_bytes;
      read_data     <= (res.status == ST_READ) ? rd_data : '0;
    end
  end

endmodule

// ----- src/mqtt_packet_receiver_core.sv -----
// MQTT packet receiver: takes one request per clock (a received byte, a
// millisecond tick, or a read of a stored byte) and gives at most one result.
// The header, its one to four remaining-length bytes and as many payload
// bytes as fit in the usable buffer are stored; reads return stored bytes
// (0 at or past the buffer depth). A result passes through the res register
// and then the output register once its request is accepted;
// in_ready drops only while both of those hold results that the consumer has
// not taken, so a full request per cycle is sustained when out_ready is high.
// Configuration writes are always taken and should be issued only while no
// packet result is pending.
module mqtt_packet_receiver_core import mqttrx_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [8:0]  packet_length,
  output logic [2:0]  length_bytes,
  output logic [7:0]  read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic      accept;
  logic      emit;
  result_t   result;
  store_wr_t store_wr;
  logic [7:0] rd_data;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  mqttrx_decode #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .func     (func),
    .rx_byte  (rx_byte),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .emit     (emit),
    .result   (result),
    .store_wr (store_wr)
  );

  mqttrx_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_en   (accept && (func == FUNC_READ)),
    .rd_index(read_index),
    .rd_data (rd_data)
  );

  mqttrx_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .emit         (emit),
    .result       (result),
    .rd_data      (rd_data),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .packet_length(packet_length),
    .length_bytes (length_bytes),
    .read_data    (read_data)
  );

  // backpressure only comes from a stalled output
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled output");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_READ)) |-> ((packet_length == '0) && (length_bytes == '0)))
    else $error("read reply carries packet fields");

  a_data_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_READ)) |-> (read_data == '0))
    else $error("read_data set on a non-read result");

  a_done_len_bytes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((status == ST_DONE) || (status == ST_OVERSIZE)))
      |-> ((length_bytes != '0) && (length_bytes <= LEN_BYTES_MAX)))
    else $error("packet result with bad length byte count");

endmodule
